@@ src/rdis_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdis_pkg: shared types and constants of the read interval set
// Item codes, the command broadcast to the interval cells and the links
// that carry data between neighboring cells.
// ----------------------------------------------------------------------------
package rdis_pkg;

  // Widths of the item fields, the per-cell count contribution and the accumulator.
  localparam int unsigned NUM_W   = 31;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned ICNT_W  = 7;
  localparam int unsigned CONT_W  = 32;
  localparam int unsigned ACC_W   = 34;

  // Item function codes.
  localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_COUNT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Largest count that the result field can show.
  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

  // Operation that every cell carries out in the current cycle.
  typedef enum logic [2:0] {
    CELL_HOLD      = 3'd0,
    CELL_CLEAR     = 3'd1,
    CELL_CAPTURE   = 3'd2,
    CELL_SHIFT     = 3'd3,
    CELL_JOIN      = 3'd4,
    CELL_EXT_LEFT  = 3'd5,
    CELL_EXT_RIGHT = 3'd6,
    CELL_INSERT    = 3'd7
  } cell_op_e;

  // Broadcast from the controller to all cells.
  typedef struct packed {
    cell_op_e           op;
    logic [NUM_W-1:0]   article;
    logic [NUM_W-1:0]   group_low;
  } cell_cmd_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic               valid;
    logic               le;
    logic [NUM_W-1:0]   low;
    logic [NUM_W-1:0]   high;
    logic [CONT_W-1:0]  contrib;
  } cell_link_t;

  // What a cell reports to the controller after a compare.
  typedef struct packed {
    logic               seen;
    logic               hit_left;
    logic               hit_right;
  } cell_flag_t;

endpackage
`default_nettype wire

@@ src/read_interval_set.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// read_interval_set: sorted set of seen-number intervals
// Top level: item control, a chain of interval cells and the count
// accumulator.
// ----------------------------------------------------------------------------
// The set is a chain of MAX_INTERVALS cells, each holding one interval in
// sorted order; an insert or a join moves the intervals one cell up or down
// the chain. Marking a number and clearing the set go through the steps
// accept, compare in every cell, update and result. A count item replaces
// the update with a sum step, in which the per-cell lengths of the intervals
// held are shifted down the chain one a cycle into a single accumulator.
// The result sits in an output register, so the next item is taken while it
// waits. The set is empty right after reset; no clearing pass is needed.
module read_interval_set
  import rdis_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input item.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: article [30:0], group_low [61:31], group_high [92:62], zero [95:93]
  input  logic [95:0] s_axis_tdata,
  // tuser: func [1:0]
  input  logic [1:0]  s_axis_tuser,
  // Result item.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: already_read [0], unread_count [31:1], table_full [32],
  //        interval_count [39:33]
  output logic [39:0] m_axis_tdata
);

  localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_ACT  = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [FUNC_W-1:0]       func_q;
  logic [NUM_W-1:0]        article_q;
  logic [NUM_W-1:0]        glo_q;
  logic [NUM_W-1:0]        ghi_q;
  logic [CNT_W-1:0]        count_q;
  logic [CNT_W-1:0]        k_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    seen_res_q;
  logic                    full_res_q;
  logic                    out_valid_q;
  logic [39:0]             out_data_q;

  cell_cmd_t               cmd;
  cell_link_t              link [MAX_INTERVALS];
  cell_flag_t              flag [MAX_INTERVALS];
  cell_link_t              edge_left;
  cell_link_t              edge_right;
  logic [MAX_INTERVALS-1:0] seen_vec;
  logic [MAX_INTERVALS-1:0] jl_vec;
  logic [MAX_INTERVALS-1:0] jr_vec;
  logic                    seen_any;
  logic                    jl_any;
  logic                    jr_any;
  logic                    is_full;
  logic                    do_mark;
  logic                    accept;
  logic                    out_free;
  logic [NUM_W-1:0]        unread;
  logic [CNT_W+ICNT_W-1:0] count_ext;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Chain ends: everything lies above the bottom end, nothing above the top.
  assign edge_left  = '{valid: 1'b0, le: 1'b1, low: '0, high: '0, contrib: '0};
  assign edge_right = '{valid: 1'b0, le: 1'b0, low: '0, high: '0, contrib: '0};

  // Row of interval cells.
  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    rdis_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  ((i == 0) ? edge_left : link[(i == 0) ? 0 : i - 1]),
      .right_i ((i == MAX_INTERVALS - 1) ? edge_right :
                link[(i == MAX_INTERVALS - 1) ? i : i + 1]),
      .link_o  (link[i]),
      .flag_o  (flag[i])
    );
    assign seen_vec[i] = flag[i].seen;
    assign jl_vec[i]   = flag[i].hit_left;
    assign jr_vec[i]   = flag[i].hit_right;
  end

  assign seen_any = |seen_vec;
  assign jl_any   = |jl_vec;
  assign jr_any   = |jr_vec;
  assign is_full  = (count_q == CNT_W'(MAX_INTERVALS));
  assign do_mark  = (func_q == FUNC_MARK) && (article_q != '0);

  // Command to the cells for the current step.
  always_comb begin
    cmd.article   = article_q;
    cmd.group_low = glo_q;
    cmd.op        = CELL_HOLD;
    case (state_q)
      ST_CMP: begin
        cmd.op = CELL_CAPTURE;
      end
      ST_SUM: begin
        if (k_q != count_q) begin
          cmd.op = CELL_SHIFT;
        end
      end
      ST_ACT: begin
        if (func_q == FUNC_CLEAR) begin
          cmd.op = CELL_CLEAR;
        end else if (do_mark && !seen_any) begin
          if (jl_any && jr_any) begin
            cmd.op = CELL_JOIN;
          end else if (jl_any) begin
            cmd.op = CELL_EXT_LEFT;
          end else if (jr_any) begin
            cmd.op = CELL_EXT_RIGHT;
          end else if (!is_full) begin
            cmd.op = CELL_INSERT;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Saturated window count.
  always_comb begin
    if ((func_q != FUNC_COUNT) || (ghi_q == '0) || acc_q[ACC_W-1]) begin
      unread = '0;
    end else if (acc_q[ACC_W-2:NUM_W] != '0) begin
      unread = NUM_MAX;
    end else begin
      unread = acc_q[NUM_W-1:0];
    end
  end

  assign count_ext = (CNT_W + ICNT_W)'(count_q);

  // Step sequence.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = (func_q == FUNC_COUNT) ? ST_SUM : ST_ACT;
      end
      ST_ACT: begin
        state_d = ST_DONE;
      end
      ST_SUM: begin
        if (k_q == count_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state: sequence, interval count, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ACT) begin
        case (cmd.op)
          CELL_CLEAR:  count_q <= '0;
          CELL_JOIN:   count_q <= count_q - CNT_W'(1);
          CELL_INSERT: count_q <= count_q + CNT_W'(1);
          default: begin
          end
        endcase
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item fields, accumulator and result data.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q    <= s_axis_tuser;
      article_q <= s_axis_tdata[30:0];
      glo_q     <= s_axis_tdata[61:31];
      ghi_q     <= s_axis_tdata[92:62];
    end
    case (state_q)
      ST_CMP: begin
        acc_q <= signed'(ACC_W'(ghi_q)) - signed'(ACC_W'(glo_q)) +
                 signed'(ACC_W'(1));
        k_q   <= '0;
      end
      ST_SUM: begin
        if (k_q != count_q) begin
          acc_q <= acc_q - signed'(ACC_W'(link[0].contrib));
          k_q   <= k_q + CNT_W'(1);
        end
      end
      ST_ACT: begin
        seen_res_q <= do_mark && seen_any;
        full_res_q <= do_mark && !seen_any && !jl_any && !jr_any && is_full;
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_q <= {count_ext[ICNT_W-1:0],
                         (func_q == FUNC_MARK) && full_res_q,
                         unread,
                         (func_q == FUNC_MARK) && seen_res_q};
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/rdis_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdis_cell: one entry of the interval chain
// Holds one closed interval, compares it against the broadcast number and
// shifts data to and from its neighbors on insert, join and count.
// ----------------------------------------------------------------------------
module rdis_cell
  import rdis_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_cmd_t  cmd_i,
  input  cell_link_t left_i,
  input  cell_link_t right_i,
  output cell_link_t link_o,
  output cell_flag_t flag_o
);

  logic              valid_q;
  logic [NUM_W-1:0]  low_q;
  logic [NUM_W-1:0]  high_q;
  logic              le_q;
  logic              seen_q;
  logic              jl_q;
  logic              jr_q;
  logic [CONT_W-1:0] contrib_q;

  logic              le_d;
  logic [CONT_W-1:0] contrib_d;
  logic [NUM_W-1:0]  start_lo;
  logic              at_left;
  logic              at_pos;

  // The number lies at or above this entry's low end.
  assign le_d = valid_q && (low_q <= cmd_i.article);

  // Length of the part of this interval at or above the window's low end.
  assign start_lo  = (low_q < cmd_i.group_low) ? cmd_i.group_low : low_q;
  assign contrib_d = (valid_q && (high_q >= cmd_i.group_low)) ?
                     (CONT_W'(high_q) - CONT_W'(start_lo) + CONT_W'(1)) : '0;

  // This entry is the last one below the number, or the first one above it.
  assign at_left = le_q && !right_i.le;
  assign at_pos  = !le_q && left_i.le;

  assign flag_o.seen      = seen_q;
  assign flag_o.hit_left  = at_left && jl_q;
  assign flag_o.hit_right = at_pos && valid_q && jr_q;

  assign link_o.valid   = valid_q;
  assign link_o.le      = le_q;
  assign link_o.low     = low_q;
  assign link_o.high    = high_q;
  assign link_o.contrib = contrib_q;

  // Control state: entry valid bit and compare flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      le_q    <= 1'b0;
      seen_q  <= 1'b0;
      jl_q    <= 1'b0;
      jr_q    <= 1'b0;
    end else begin
      case (cmd_i.op)
        CELL_CLEAR: begin
          valid_q <= 1'b0;
        end
        CELL_CAPTURE: begin
          le_q   <= le_d;
          seen_q <= le_d && (high_q >= cmd_i.article);
          jl_q   <= valid_q && ((CONT_W'(high_q) + CONT_W'(1)) == CONT_W'(cmd_i.article));
          jr_q   <= valid_q && (CONT_W'(low_q) == (CONT_W'(cmd_i.article) + CONT_W'(1)));
        end
        CELL_JOIN: begin
          if (!le_q) begin
            valid_q <= right_i.valid;
          end
        end
        CELL_INSERT: begin
          if (at_pos) begin
            valid_q <= 1'b1;
          end else if (!le_q) begin
            valid_q <= left_i.valid;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Interval bounds and the count contribution.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CELL_CAPTURE: begin
        contrib_q <= contrib_d;
      end
      CELL_SHIFT: begin
        contrib_q <= right_i.contrib;
      end
      CELL_JOIN: begin
        if (at_left) begin
          high_q <= right_i.high;
        end else if (!le_q) begin
          low_q  <= right_i.low;
          high_q <= right_i.high;
        end
      end
      CELL_EXT_LEFT: begin
        if (at_left) begin
          high_q <= cmd_i.article;
        end
      end
      CELL_EXT_RIGHT: begin
        if (at_pos) begin
          low_q <= cmd_i.article;
        end
      end
      CELL_INSERT: begin
        if (at_pos) begin
          low_q  <= cmd_i.article;
          high_q <= cmd_i.article;
        end else if (!le_q) begin
          low_q  <= left_i.low;
          high_q <= left_i.high;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/rdis_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdis_checker: port-level checks of the read interval set
// Watches the item ports of the top level and flags impossible results.
// ----------------------------------------------------------------------------
module rdis_checker
  import rdis_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [95:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // A held result keeps its data until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One item is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item taken while another is in work");

  // A number is either already held or finds the table full, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[32]))
    else $error("already read and table full together");

  // Mark results that are already read or find the table full carry no window count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[0] || m_axis_tdata[32]) |->
    m_axis_tdata[31:1] == 31'd0)
    else $error("count shown on a mark result");

  // When the input opens again after a clear, its result shows an empty set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_CLEAR) |=>
    s_axis_tready [->1] ##0 m_axis_tvalid && (m_axis_tdata[39:33] == 7'd0))
    else $error("clear left intervals behind");

endmodule

bind read_interval_set rdis_checker u_rdis_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
